>>> sv/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest path block.
`default_nettype none
package apsp_pkg;
  localparam int NODES = 64;
  localparam int IDX_W = $clog2(NODES);
  localparam int DIST_W = 16;

  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef dist_t [NODES-1:0] row_t;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam dist_t DIST_MAX = '1;
endpackage
`default_nettype wire

>>> sv/apsp_ifc.sv
// Request and response channel interfaces.
`default_nettype none
interface apsp_req_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [5:0] row;
  logic [5:0] col;
  logic [15:0] distance;
  modport source (output valid, mode, row, col, distance, input ready);
  modport sink (input valid, mode, row, col, distance, output ready);
endinterface

interface apsp_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] done_mode;
  logic [15:0] read_distance;
  modport source (output valid, done_mode, read_distance, input ready);
  modport sink (input valid, done_mode, read_distance, output ready);
endinterface
`default_nettype wire

>>> sv/all_pairs_shortest_path.sv
// Top level: Floyd-Warshall distance matrix with write, read and closure commands.
`default_nettype none
// Holds a NODES x NODES matrix of 16-bit distances in a row-wide memory.
// After reset a clearing pass writes one zero row per cycle with req.ready
// low. A write is stored when accepted; a read answers from a registered
// memory read. A run loads pivot row k into a row of NODES cells, then
// relaxes every row i in turn (relax into a register, write back) through
// the single memory port pair. Sums through the pivot saturate at 65535.
// One response per request.
module all_pairs_shortest_path (
  input wire logic   clk,
  input wire logic   rst,
  apsp_req_if.sink   req,
  apsp_rsp_if.source rsp
);
  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_KRD  = 7'b0001000,
    S_KLD  = 7'b0010000,
    S_ICMP = 7'b0100000,
    S_IWR  = 7'b1000000
  } state_t;

  localparam apsp_pkg::idx_t LAST = apsp_pkg::IDX_W'(apsp_pkg::NODES - 1);

  state_t state, state_next;
  apsp_pkg::row_t mem [apsp_pkg::NODES];
  apsp_pkg::row_t rdata;
  apsp_pkg::row_t wrow;
  apsp_pkg::row_t relaxed;
  apsp_pkg::idx_t kidx, iidx, cidx, col_q;
  logic rsp_valid;
  logic [1:0] rsp_mode;
  apsp_pkg::dist_t rsp_dist;
  logic accept, in_range, cell_load;
  logic in_range_q;
  apsp_pkg::idx_t ridx_in, cidx_in;
  logic re;
  apsp_pkg::idx_t raddr;

  assign ridx_in = apsp_pkg::IDX_W'(req.row);
  assign cidx_in = apsp_pkg::IDX_W'(req.col);
  assign in_range = (int'(req.row) < apsp_pkg::NODES) && (int'(req.col) < apsp_pkg::NODES);
  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept = req.valid && req.ready;
  assign cell_load = (state == S_KLD);

  assign rsp.valid = rsp_valid;
  assign rsp.done_mode = rsp_mode;
  assign rsp.read_distance = rsp_dist;

  for (genvar j = 0; j < apsp_pkg::NODES; j++) begin : g_cell
    apsp_cell u_cell (
      .clk   (clk),
      .load  (cell_load),
      .kin   (rdata[j]),
      .ent   (rdata[j]),
      .pivot (rdata[kidx]),
      .nxt   (relaxed[j])
    );
  end

  always_comb begin
    re = 1'b0;
    raddr = iidx;
    state_next = state;
    case (state)
      S_CLR: begin
        if (cidx == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && req.mode == apsp_pkg::MODE_READ) begin
          re = 1'b1;
          raddr = ridx_in;
          state_next = S_RD;
        end else if (accept && req.mode == apsp_pkg::MODE_RUN) begin
          state_next = S_KRD;
        end
      end
      S_RD: state_next = S_IDLE;
      S_KRD: begin
        re = 1'b1;
        raddr = kidx;
        state_next = S_KLD;
      end
      S_KLD: begin
        re = 1'b1;
        raddr = '0;
        state_next = S_ICMP;
      end
      S_ICMP: state_next = S_IWR;
      S_IWR: begin
        if (iidx != LAST) begin
          re = 1'b1;
          raddr = iidx + 1'b1;
          state_next = S_ICMP;
        end else if (kidx != LAST) begin
          state_next = S_KRD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      mem[cidx] <= '0;
    end else if (state == S_IWR) begin
      mem[iidx] <= wrow;
    end else if (accept && req.mode == apsp_pkg::MODE_WRITE && in_range) begin
      mem[ridx_in][cidx_in] <= req.distance;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ICMP) wrow <= relaxed;
    if (accept) col_q <= in_range ? cidx_in : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cidx <= '0;
      kidx <= '0;
      iidx <= '0;
      rsp_valid <= 1'b0;
      rsp_mode <= '0;
      rsp_dist <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) cidx <= cidx + 1'b1;
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            kidx <= '0;
            iidx <= '0;
            rsp_mode <= req.mode;
            rsp_dist <= '0;
            rsp_valid <= (req.mode != apsp_pkg::MODE_READ) &&
                         (req.mode != apsp_pkg::MODE_RUN);
          end
        end
        S_RD: begin
          rsp_valid <= 1'b1;
          rsp_dist <= in_range_q ? rdata[col_q] : '0;
        end
        S_KLD: iidx <= '0;
        S_IWR: begin
          if (iidx != LAST) begin
            iidx <= iidx + 1'b1;
          end else if (kidx != LAST) begin
            kidx <= kidx + 1'b1;
          end else begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_range_q <= in_range;
  end
endmodule
`default_nettype wire

>>> sv/apsp_cell.sv
// Relaxation cell: holds one pivot-row entry and relaxes one column of the current row.
`default_nettype none
module apsp_cell (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire apsp_pkg::dist_t kin,
  input  wire apsp_pkg::dist_t ent,
  input  wire apsp_pkg::dist_t pivot,
  output apsp_pkg::dist_t    nxt
);
  apsp_pkg::dist_t kval;
  logic [apsp_pkg::DIST_W:0] sum;
  apsp_pkg::dist_t via;

  always_ff @(posedge clk) begin
    if (load) begin
      kval <= kin;
    end
  end

  always_comb begin
    sum = {1'b0, pivot} + {1'b0, kval};
    via = sum[apsp_pkg::DIST_W] ? apsp_pkg::DIST_MAX : sum[apsp_pkg::DIST_W-1:0];
    nxt = (via < ent) ? via : ent;
  end
endmodule
`default_nettype wire

>>> bench/tb_all_pairs_shortest_path.sv
// Testbench for the all-pairs shortest path block: directed table, random traffic, predictor.
`default_nettype none
module tb_all_pairs_shortest_path;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 40000;
  localparam int RAND_ITEMS = 1500;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic [15:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [1:0] done_mode;
    logic [15:0] read_distance;
  } answer_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    answer_t answer;
  } dir_row_t;

  logic clk;
  logic rst;
  apsp_req_if req ();
  apsp_rsp_if rsp ();

  all_pairs_shortest_path DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  apsp_pkg::dist_t dist_m [apsp_pkg::NODES][apsp_pkg::NODES];
  answer_t answer_q [$];
  int mismatches;
  int idle_cycles;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int stall_style;
  int stall_phase;
  int burst_left;
  bit no_gaps;

  dir_row_t dir_tab [22] = '{
    '{'{apsp_pkg::MODE_READ, 6'd0, 6'd0, 16'd0}, 1'b1, '{apsp_pkg::MODE_READ, 16'd0}},
    '{'{apsp_pkg::MODE_READ, 6'd63, 6'd63, 16'hFFFF}, 1'b1, '{apsp_pkg::MODE_READ, 16'd0}},
    '{'{apsp_pkg::MODE_WRITE, 6'd0, 6'd0, 16'hFFFF}, 1'b1, '{apsp_pkg::MODE_WRITE, 16'd0}},
    '{'{apsp_pkg::MODE_READ, 6'd0, 6'd0, 16'd0}, 1'b1, '{apsp_pkg::MODE_READ, 16'hFFFF}},
    '{'{apsp_pkg::MODE_WRITE, 6'd63, 6'd63, 16'd0}, 1'b1, '{apsp_pkg::MODE_WRITE, 16'd0}},
    '{'{MODE_SPARE, 6'd21, 6'd42, 16'hAAAA}, 1'b1, '{MODE_SPARE, 16'd0}},
    '{'{MODE_SPARE, 6'd63, 6'd0, 16'h5555}, 1'b1, '{MODE_SPARE, 16'd0}},
    '{'{apsp_pkg::MODE_WRITE, 6'd0, 6'd1, 16'd100}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd1, 6'd2, 16'd200}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd0, 6'd2, 16'hFFFF}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd2, 6'd0, 16'd65000}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd1, 6'd0, 16'hFFFF}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd2, 6'd3, 16'd40000}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd3, 6'd4, 16'd40000}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd5, 6'd5, 16'd7}, 1'b0, '0},
    '{'{apsp_pkg::MODE_WRITE, 6'd5, 6'd6, 16'd10}, 1'b0, '0},
    '{'{apsp_pkg::MODE_RUN, 6'd0, 6'd0, 16'd0}, 1'b1, '{apsp_pkg::MODE_RUN, 16'd0}},
    '{'{apsp_pkg::MODE_READ, 6'd0, 6'd2, 16'd0}, 1'b0, '0},
    '{'{apsp_pkg::MODE_READ, 6'd2, 6'd4, 16'd0}, 1'b0, '0},
    '{'{apsp_pkg::MODE_READ, 6'd5, 6'd6, 16'd0}, 1'b0, '0},
    '{'{apsp_pkg::MODE_READ, 6'd1, 6'd0, 16'd0}, 1'b0, '0},
    '{'{apsp_pkg::MODE_READ, 6'd63, 6'd63, 16'd0}, 1'b0, '0}
  };

  function automatic apsp_pkg::dist_t sat_sum(apsp_pkg::dist_t a, apsp_pkg::dist_t b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s > 17'h0FFFF ? apsp_pkg::DIST_MAX : s[15:0];
  endfunction

  function automatic void relax_all();
    apsp_pkg::dist_t via;
    for (int k = 0; k < apsp_pkg::NODES; k++)
      for (int i = 0; i < apsp_pkg::NODES; i++)
        for (int j = 0; j < apsp_pkg::NODES; j++) begin
          via = sat_sum(dist_m[i][k], dist_m[k][j]);
          if (via < dist_m[i][j]) dist_m[i][j] = via;
        end
  endfunction

  function automatic answer_t apply_cmd(cmd_t c);
    answer_t a;
    a.done_mode = c.mode;
    a.read_distance = '0;
    case (c.mode)
      apsp_pkg::MODE_WRITE: dist_m[c.row][c.col] = c.distance;
      apsp_pkg::MODE_RUN: relax_all();
      apsp_pkg::MODE_READ: a.read_distance = dist_m[c.row][c.col];
      default: ;
    endcase
    return a;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(0, 999);
    c.mode = r < 6 ? apsp_pkg::MODE_RUN :
             r < 40 ? MODE_SPARE :
             r < 520 ? apsp_pkg::MODE_WRITE : apsp_pkg::MODE_READ;
    if ($urandom_range(0, 3) == 0) begin
      c.row = 6'($urandom);
      c.col = 6'($urandom);
    end else begin
      c.row = 6'($urandom_range(0, 7));
      c.col = 6'($urandom_range(0, 7));
    end
    case ($urandom_range(0, 4))
      0: c.distance = apsp_pkg::DIST_MAX;
      1: c.distance = 16'($urandom_range(0, 50));
      2: c.distance = 16'($urandom_range(30000, 65534));
      default: c.distance = 16'($urandom);
    endcase
    return c;
  endfunction

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic send_cmd(cmd_t c, logic typed, answer_t typed_answer);
    answer_t a;
    req.valid <= 1'b1;
    req.mode <= c.mode;
    req.row <= c.row;
    req.col <= c.col;
    req.distance <= c.distance;
    do @(posedge clk); while (!req.ready);
    a = apply_cmd(c);
    answer_q.push_back(typed ? typed_answer : a);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 20);
      if (!no_gaps) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp.ready <= 1'b0;
    end else begin
      if (stall_phase == 0) begin
        stall_style <= $urandom_range(0, 2);
        stall_phase <= 300;
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_style)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= 1'($urandom_range(0, 1));
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rsp.valid && rsp.ready) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: mode %0d distance %0d",
                   rsp.done_mode, rsp.read_distance);
      end else begin
        want = answer_q.pop_front();
        if (rsp.done_mode !== want.done_mode || rsp.read_distance !== want.read_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mode %0d distance %0d, got mode %0d distance %0d",
                     want.done_mode, want.read_distance, rsp.done_mode, rsp.read_distance);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    rst = 1'b1;
    req.valid = 1'b0;
    req.mode = apsp_pkg::MODE_WRITE;
    req.row = '0;
    req.col = '0;
    req.distance = '0;
    rsp.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    stall_style = 0;
    stall_phase = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < apsp_pkg::NODES; i++)
      for (int j = 0; j < apsp_pkg::NODES; j++) dist_m[i][j] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[n]) send_cmd(dir_tab[n].cmd, dir_tab[n].typed, dir_tab[n].answer);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (n == 300 || n == 1100) begin
        hold_req++;
        no_gaps = 1'b1;
        for (int m = 0; m < 80; m++) begin
          c = random_cmd();
          if (c.mode == apsp_pkg::MODE_RUN) c.mode = apsp_pkg::MODE_READ;
          send_cmd(c, 1'b0, '0);
        end
        no_gaps = 1'b0;
      end
      c = random_cmd();
      if ((c.mode == apsp_pkg::MODE_RUN && $urandom_range(0, 1) == 0) || n == 700) begin
        req.valid <= 1'b0;
        wait (answer_q.size() == 0);
        @(negedge clk);
      end
      send_cmd(c, 1'b0, '0);
    end
    req.valid <= 1'b0;

    wait (answer_q.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
